### rtl/core/slpdc_pkg.sv
package slpdc_pkg;

  // Field and register widths
  localparam int unsigned GainW    = 24;
  localparam int unsigned LimW     = 26;
  localparam int unsigned DevW     = 27;
  localparam int unsigned WideW    = 28;
  localparam int unsigned TimerW   = 28;
  localparam int unsigned ErrW     = 16;
  localparam int unsigned BlkW     = 16;
  localparam int unsigned ElapsedW = 20;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 28;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 32;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN        = 3'd0,
    REG_INTEG_GAIN       = 3'd1,
    REG_MAX_DEVIATION    = 3'd2,
    REG_SLEW_PER_SAMPLE  = 3'd3,
    REG_EXCESS_THRESHOLD = 3'd4,
    REG_SUSTAIN_TIME     = 3'd5
  } cfg_reg_e;

  // Word kinds
  typedef enum logic {
    KIND_UPDATE = 1'b0,
    KIND_CHECK  = 1'b1
  } kind_e;

  typedef logic signed [WideW-1:0] wide_t;

  // Clamp to the symmetric range -lim .. +lim
  function automatic wide_t clamp_sym(input wide_t v, input wide_t lim);
    wide_t r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/core/slew_limited_pi_drift_controller.sv
// Slew-limited PI drift controller. An update word (tuser 0) carries a Q0.15
// fill error and a block length; the PI target, clamped to max_deviation, is
// approached by at most slew_per_sample * block_samples / 2^16 per update, and
// the integral is committed only when that step was not limited. A check word
// (tuser 1) carries elapsed microseconds and drives a saturating excess-drift
// timer and the sustained_drift flag. Every word yields one result word holding
// the deviation (signed Q16 ppm) and the flag. Rate: one word per clock cycle
// while no result word is held by a low m_axis_tready. A taken word loads the
// input register with the scaled gain and slew products; as it advances, the
// controller state is updated and the result register is loaded.
// The input side stalls only while a result word is held by a low m_axis_tready.
// Configuration writes take effect on the next clock edge.
module slew_limited_pi_drift_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [slpdc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [slpdc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] fill_error, [31:16] block_samples, [51:32] elapsed_us, [55:52] zero
  input  logic [slpdc_pkg::InDataW-1:0]     s_axis_tdata,
  // [0] kind
  input  logic                              s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [26:0] deviation, [27] sustained_drift, [31:28] zero
  output logic [slpdc_pkg::OutDataW-1:0]    m_axis_tdata
);

  localparam int unsigned PW = slpdc_pkg::GainW + slpdc_pkg::ErrW + 1;
  localparam int unsigned SW = slpdc_pkg::GainW + slpdc_pkg::BlkW;

  // Configuration registers
  logic [slpdc_pkg::GainW-1:0]  prop_gain_q, integ_gain_q, slew_q;
  logic [slpdc_pkg::LimW-1:0]   max_dev_q, thresh_q;
  logic [slpdc_pkg::TimerW-1:0] sustain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= '0;
      integ_gain_q <= '0;
      max_dev_q    <= '0;
      slew_q       <= '0;
      thresh_q     <= '0;
      sustain_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (slpdc_pkg::cfg_reg_e'(cfg_idx_i))
        slpdc_pkg::REG_PROP_GAIN:        prop_gain_q  <= cfg_wdata_i[slpdc_pkg::GainW-1:0];
        slpdc_pkg::REG_INTEG_GAIN:       integ_gain_q <= cfg_wdata_i[slpdc_pkg::GainW-1:0];
        slpdc_pkg::REG_MAX_DEVIATION:    max_dev_q    <= cfg_wdata_i[slpdc_pkg::LimW-1:0];
        slpdc_pkg::REG_SLEW_PER_SAMPLE:  slew_q       <= cfg_wdata_i[slpdc_pkg::GainW-1:0];
        slpdc_pkg::REG_EXCESS_THRESHOLD: thresh_q     <= cfg_wdata_i[slpdc_pkg::LimW-1:0];
        slpdc_pkg::REG_SUSTAIN_TIME:     sustain_q    <= cfg_wdata_i[slpdc_pkg::TimerW-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input word
  logic signed [slpdc_pkg::ErrW-1:0] in_err;
  logic [slpdc_pkg::BlkW-1:0]        in_blk;
  logic [slpdc_pkg::ElapsedW-1:0]    in_el;

  assign in_err = $signed(s_axis_tdata[15:0]);
  assign in_blk = s_axis_tdata[31:16];
  assign in_el  = s_axis_tdata[51:32];

  // Gain and slew products, formed as the word is taken
  logic signed [PW-1:0] p_prod, di_prod;
  logic [SW-1:0]        step_prod;

  assign p_prod    = $signed({1'b0, prop_gain_q}) * in_err;
  assign di_prod   = $signed({1'b0, integ_gain_q}) * in_err;
  assign step_prod = slew_q * in_blk;

  // Input register stage
  logic                                  s1_valid_q;
  logic                                  s1_kind_q;
  logic signed [PW-16-1:0]               s1_p_q, s1_di_q;
  logic [slpdc_pkg::GainW-1:0]           s1_step_q;
  logic [slpdc_pkg::ElapsedW-1:0]        s1_el_q;
  logic                                  advance;
  logic                                  in_take;

  assign advance       = s1_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  // Floor shifts are arithmetic shifts: keep the upper bits, the top one is
  // only a copy of the sign
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_kind_q <= s_axis_tuser;
      s1_p_q    <= p_prod[PW-2:15];
      s1_di_q   <= di_prod[PW-2:15];
      s1_step_q <= step_prod[SW-1:16];
      s1_el_q   <= in_el;
    end
  end

  // Controller state
  logic signed [slpdc_pkg::DevW-1:0] integ_q, integ_d;
  logic signed [slpdc_pkg::DevW-1:0] dev_q, dev_d;
  logic [slpdc_pkg::TimerW-1:0]      timer_q, timer_d;
  logic                              flag_q, flag_d;

  slpdc_pkg::wide_t lim, cand, tgt, want, delta, step_w, dev_sum;
  logic [slpdc_pkg::DevW-1:0]        mag;
  logic [slpdc_pkg::TimerW:0]        timer_sum;
  logic                              excess;

  assign lim    = $signed({2'b00, max_dev_q});
  assign step_w = $signed({4'b0000, s1_step_q});
  assign mag    = dev_q[slpdc_pkg::DevW-1] ? slpdc_pkg::DevW'(-dev_q) : dev_q;
  assign excess = mag > {1'b0, thresh_q};
  assign timer_sum = {1'b0, timer_q} + (slpdc_pkg::TimerW+1)'(s1_el_q);

  // Work out the next state for the word in the input register
  always_comb begin
    cand    = slpdc_pkg::clamp_sym(slpdc_pkg::WideW'(integ_q) + slpdc_pkg::WideW'(s1_di_q),
                                   lim);
    tgt     = slpdc_pkg::clamp_sym(slpdc_pkg::WideW'(s1_p_q) + cand, lim);
    want    = tgt - slpdc_pkg::WideW'(dev_q);
    delta   = slpdc_pkg::clamp_sym(want, step_w);
    dev_sum = slpdc_pkg::clamp_sym(slpdc_pkg::WideW'(dev_q) + delta, lim);
    integ_d = integ_q;
    dev_d   = dev_q;
    timer_d = timer_q;
    flag_d  = flag_q;
    unique case (slpdc_pkg::kind_e'(s1_kind_q))
      slpdc_pkg::KIND_UPDATE: begin
        // commit the integral only when the step was not slew-limited
        if (delta == want) begin
          integ_d = slpdc_pkg::DevW'(cand);
        end
        dev_d = slpdc_pkg::DevW'(dev_sum);
      end
      slpdc_pkg::KIND_CHECK: begin
        if (excess) begin
          timer_d = timer_sum[slpdc_pkg::TimerW] ? '1 : timer_sum[slpdc_pkg::TimerW-1:0];
          if (timer_d >= sustain_q) begin
            flag_d = 1'b1;
          end
        end else begin
          timer_d = '0;
          flag_d  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Advance state and load the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q       <= '0;
      dev_q         <= '0;
      timer_q       <= '0;
      flag_q        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        integ_q <= integ_d;
        dev_q   <= dev_d;
        timer_q <= timer_d;
        flag_q  <= flag_d;
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {4'b0000, flag_q, dev_q};

  // Result word always mirrors the committed state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[26:0] == dev_q && m_axis_tdata[27] == flag_q))
    else $error("result word out of step with state");

  // A word leaving the input stage always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("advanced word lost");

  // Input stage full and blocked: take nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |-> !s_axis_tready)
    else $error("input accepted over a held word");

  // An update word leaves the timer and the flag alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_kind_q == slpdc_pkg::KIND_UPDATE) |=> ($stable(timer_q) && $stable(flag_q)))
    else $error("update word disturbed drift timer");

  // A check below the threshold clears the timer and the flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_kind_q == slpdc_pkg::KIND_CHECK && !excess) |=> (timer_q == '0 && !flag_q))
    else $error("drift timer not cleared");

endmodule

### tb/tb_slew_limited_pi_drift_controller.sv
`timescale 1ns / 100ps

module tb_slew_limited_pi_drift_controller;

  // Index codes past the end of the register list
  localparam logic [slpdc_pkg::CfgIdxW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [slpdc_pkg::CfgIdxW-1:0] REG_SPARE_B = 3'd7;

  // Field positions in the input word
  localparam int unsigned BlkLsb = slpdc_pkg::ErrW;
  localparam int unsigned ElLsb  = slpdc_pkg::ErrW + slpdc_pkg::BlkW;

  localparam int unsigned PhaseWords = 45;
  localparam int unsigned SatWords   = 275;
  localparam int unsigned HoldCycles = 400;

  typedef enum {RX_OPEN, RX_RANDOM, RX_SHUT} rx_mode_e;

  // Tracks controller state and the deviation/flag words it should emit
  class drift_tracker;
    logic [slpdc_pkg::GainW-1:0]        prop_gain, integ_gain, slew;
    logic [slpdc_pkg::LimW-1:0]         max_dev, threshold;
    logic [slpdc_pkg::TimerW-1:0]       sustain;
    logic signed [slpdc_pkg::DevW-1:0]  integ_acc, deviation;
    logic [slpdc_pkg::TimerW-1:0]       excess_timer;
    logic                               drift_flag;
    logic [slpdc_pkg::OutDataW-1:0]     dev_flag_q[$];
    int unsigned                        n_errors, n_updates, n_checks, n_seen;

    function new();
      prop_gain = '0; integ_gain = '0; slew = '0;
      max_dev = '0; threshold = '0; sustain = '0;
      integ_acc = '0; deviation = '0; excess_timer = '0; drift_flag = 1'b0;
      n_errors = 0; n_updates = 0; n_checks = 0; n_seen = 0;
    endfunction

    function longint bound(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void write_reg(logic [slpdc_pkg::CfgIdxW-1:0] idx,
                            logic [slpdc_pkg::CfgDataW-1:0] v);
      unique case (idx)
        slpdc_pkg::REG_PROP_GAIN:        prop_gain  = v[slpdc_pkg::GainW-1:0];
        slpdc_pkg::REG_INTEG_GAIN:       integ_gain = v[slpdc_pkg::GainW-1:0];
        slpdc_pkg::REG_MAX_DEVIATION:    max_dev    = v[slpdc_pkg::LimW-1:0];
        slpdc_pkg::REG_SLEW_PER_SAMPLE:  slew       = v[slpdc_pkg::GainW-1:0];
        slpdc_pkg::REG_EXCESS_THRESHOLD: threshold  = v[slpdc_pkg::LimW-1:0];
        slpdc_pkg::REG_SUSTAIN_TIME:     sustain    = v[slpdc_pkg::TimerW-1:0];
        default: ;
      endcase
    endfunction

    // Advance the controller by one accepted word and queue its output
    function void note_word(logic kind, logic [slpdc_pkg::InDataW-1:0] d);
      longint err, blk, el, lim, p, di, cand, tgt, stp, want, delta, mag, t;
      if (kind == slpdc_pkg::KIND_UPDATE) begin
        n_updates++;
        err   = longint'($signed(d[slpdc_pkg::ErrW-1:0]));
        blk   = longint'(d[ElLsb-1:BlkLsb]);
        lim   = longint'(max_dev);
        p     = (longint'(prop_gain) * err) >>> 15;
        di    = (longint'(integ_gain) * err) >>> 15;
        cand  = bound(longint'(integ_acc) + di, lim);
        tgt   = bound(p + cand, lim);
        stp   = (longint'(slew) * blk) >>> 16;
        want  = tgt - longint'(deviation);
        delta = bound(want, stp);
        // commit the integral only when the step was not slew limited
        if (delta == want) integ_acc = cand[slpdc_pkg::DevW-1:0];
        t = bound(longint'(deviation) + delta, lim);
        deviation = t[slpdc_pkg::DevW-1:0];
      end else begin
        n_checks++;
        el  = longint'(d[ElLsb+slpdc_pkg::ElapsedW-1:ElLsb]);
        mag = (deviation < 0) ? -longint'(deviation) : longint'(deviation);
        if (mag > longint'(threshold)) begin
          t = longint'(excess_timer) + el;
          if (t > longint'({slpdc_pkg::TimerW{1'b1}})) t = longint'({slpdc_pkg::TimerW{1'b1}});
          excess_timer = t[slpdc_pkg::TimerW-1:0];
          if (excess_timer >= sustain) drift_flag = 1'b1;
        end else begin
          excess_timer = '0;
          drift_flag = 1'b0;
        end
      end
      dev_flag_q.push_back({4'b0, drift_flag, deviation});
    endfunction

    // Compare one result word with the oldest queued output
    function void check_word(logic [slpdc_pkg::OutDataW-1:0] got);
      logic [slpdc_pkg::OutDataW-1:0] exp_w;
      n_seen++;
      if (dev_flag_q.size() == 0) begin
        n_errors++;
        $display("%0t: result %h arrived with nothing outstanding", $time, got);
        return;
      end
      exp_w = dev_flag_q.pop_front();
      if (got[slpdc_pkg::DevW-1:0] !== exp_w[slpdc_pkg::DevW-1:0]) begin
        n_errors++;
        $display("%0t: deviation expected %0d got %0d", $time,
                 $signed(exp_w[slpdc_pkg::DevW-1:0]), $signed(got[slpdc_pkg::DevW-1:0]));
      end
      if (got[slpdc_pkg::DevW] !== exp_w[slpdc_pkg::DevW]) begin
        n_errors++;
        $display("%0t: sustained_drift expected %b got %b", $time,
                 exp_w[slpdc_pkg::DevW], got[slpdc_pkg::DevW]);
      end
    endfunction

    function int unsigned pending();
      return dev_flag_q.size();
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [slpdc_pkg::CfgIdxW-1:0]     cfg_idx_i;
  logic [slpdc_pkg::CfgDataW-1:0]    cfg_wdata_i;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  // [15:0] fill_error, [31:16] block_samples, [51:32] elapsed_us, [55:52] zero
  logic [slpdc_pkg::InDataW-1:0]     s_axis_tdata;
  // [0] kind
  logic                              s_axis_tuser;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  // [26:0] deviation, [27] sustained_drift, [31:28] zero
  logic [slpdc_pkg::OutDataW-1:0]    m_axis_tdata;

  drift_tracker board;
  bit           hold_off_req;
  int unsigned  tx_burst;
  int unsigned  n_settings;

  slew_limited_pi_drift_controller DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Track register writes and accepted words on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) board.write_reg(cfg_idx_i, cfg_wdata_i);
    if (rst_ni && s_axis_tvalid && s_axis_tready) board.note_word(s_axis_tuser, s_axis_tdata);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata);
  end

  // Result side: open, random and shut stretches, plus one long hold-off
  initial begin
    rx_mode_e    mode;
    int unsigned left;
    int unsigned r;
    bit          held;
    mode = RX_OPEN;
    left = 0;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        if (left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 40) begin
            mode = RX_OPEN;
            left = $urandom_range(5, 60);
          end else if (r < 85) begin
            mode = RX_RANDOM;
            left = $urandom_range(5, 60);
          end else begin
            mode = RX_SHUT;
            left = (r < 97) ? $urandom_range(1, 3) : $urandom_range(15, 40);
          end
        end
        left--;
        unique case (mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default:   m_axis_tready <= 1'b0;
        endcase
      end
    end
  end

  // Mostly short gaps, a few long ones, and idle-free bursts
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_burst > 0) begin
      tx_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      tx_burst = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned pick_value(int unsigned maxv, int unsigned typical);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return maxv;
    if (r < 7) return $urandom_range(0, typical);
    return $urandom_range(0, maxv);
  endfunction

  // Offer one word and hold it until accepted; returns at a falling edge
  task automatic send_word(slpdc_pkg::kind_e k, logic [slpdc_pkg::InDataW-1:0] d);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= k;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Unused fields carry random junk
  task automatic send_update(logic [slpdc_pkg::ErrW-1:0] err, logic [slpdc_pkg::BlkW-1:0] blk);
    logic [slpdc_pkg::ElapsedW-1:0] junk;
    junk = slpdc_pkg::ElapsedW'($urandom);
    send_word(slpdc_pkg::KIND_UPDATE, {4'b0, junk, blk, err});
  endtask

  task automatic send_check(logic [slpdc_pkg::ElapsedW-1:0] el);
    logic [31:0] junk;
    junk = $urandom;
    send_word(slpdc_pkg::KIND_CHECK, {4'b0, el, junk});
  endtask

  task automatic cfg_write(logic [slpdc_pkg::CfgIdxW-1:0] idx,
                           logic [slpdc_pkg::CfgDataW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(int unsigned pg, int unsigned ig, int unsigned md,
                                int unsigned sl, int unsigned th, int unsigned su);
    n_settings++;
    cfg_write(slpdc_pkg::REG_PROP_GAIN, slpdc_pkg::CfgDataW'(pg));
    cfg_write(slpdc_pkg::REG_INTEG_GAIN, slpdc_pkg::CfgDataW'(ig));
    cfg_write(slpdc_pkg::REG_MAX_DEVIATION, slpdc_pkg::CfgDataW'(md));
    cfg_write(slpdc_pkg::REG_SLEW_PER_SAMPLE, slpdc_pkg::CfgDataW'(sl));
    cfg_write(slpdc_pkg::REG_EXCESS_THRESHOLD, slpdc_pkg::CfgDataW'(th));
    cfg_write(slpdc_pkg::REG_SUSTAIN_TIME, slpdc_pkg::CfgDataW'(su));
    cfg_we_i <= 1'b0;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    int unsigned ph, i, r, rr;
    logic [slpdc_pkg::ErrW-1:0]     e;
    logic [slpdc_pkg::BlkW-1:0]     b;
    logic [slpdc_pkg::ElapsedW-1:0] el;
    board = new();
    hold_off_req = 1'b0;
    tx_burst = 0;
    n_settings = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = slpdc_pkg::KIND_UPDATE;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values: all gains and limits zero
    send_update(16'h1234, 16'd300);
    send_check(20'd77);
    drain();

    // Every register at its maximum, zero threshold and zero sustain time
    apply_settings('hFFFFFF, 'hFFFFFF, 'h3FFFFFF, 'hFFFFFF, 0, 0);
    send_update(16'h7FFF, 16'hFFFF);
    send_update(16'h8000, 16'hFFFF);
    send_update(16'h0000, 16'h0000);
    send_check(20'd0);
    send_check(20'hFFFFF);
    send_update(16'h8000, 16'd1);
    send_update(16'h7FFF, 16'hFFFF);
    drain();

    // Zero slew: deviation holds
    cfg_write(slpdc_pkg::REG_SLEW_PER_SAMPLE, 28'd0);
    cfg_we_i <= 1'b0;
    send_update(16'h8000, 16'd500);
    send_update(16'h0000, 16'hFFFF);
    send_check(20'd1);
    drain();

    // Lowered limit clamps the deviation; the flag stays set
    cfg_write(slpdc_pkg::REG_MAX_DEVIATION, 28'd5000);
    cfg_write(slpdc_pkg::REG_SLEW_PER_SAMPLE, 28'h100000);
    cfg_write(slpdc_pkg::REG_EXCESS_THRESHOLD, 28'd4000);
    cfg_write(slpdc_pkg::REG_SUSTAIN_TIME, 28'd2000);
    cfg_we_i <= 1'b0;
    send_update(16'h0000, 16'd100);
    send_check(20'd1000);
    send_check(20'd1500);
    drain();

    // Flag holds after sustain time grows; writes past the list do nothing
    cfg_write(slpdc_pkg::REG_SUSTAIN_TIME, 28'hFFFFFFF);
    cfg_write(REG_SPARE_A, 28'hFFFFFFF);
    cfg_write(REG_SPARE_B, 28'hFFFFFFF);
    cfg_we_i <= 1'b0;
    send_check(20'd10);
    send_check(20'hFFFFF);
    drain();

    // Threshold at maximum clears timer and flag
    cfg_write(slpdc_pkg::REG_EXCESS_THRESHOLD, 28'h3FFFFFF);
    cfg_we_i <= 1'b0;
    send_check(20'd5);
    drain();

    // Timer saturation, with the result side held off for a long stretch
    apply_settings('h8000, 0, 'h3FFFFFF, 'hFFFFFF, 0, 'hFFFFFFF);
    send_update(16'h7FFF, 16'hFFFF);
    hold_off_req = 1'b1;
    for (i = 0; i < SatWords; i++) begin
      send_check(20'hFFFFF - 20'($urandom_range(0, 255)));
    end
    send_check(20'd0);
    drain();

    // Random phases: extremes first, then random settings
    for (ph = 0; ph < 6; ph++) begin
      drain();
      if (ph == 0) begin
        apply_settings('hFFFFFF, 'hFFFFFF, 'h3FFFFFF, 'hFFFFFF, 'h3FFFFFF, 'hFFFFFFF);
      end else if (ph == 1) begin
        apply_settings(0, 0, 0, 0, 0, 0);
      end else begin
        apply_settings(pick_value('hFFFFFF, 'h20000), pick_value('hFFFFFF, 'h4000),
                       pick_value('h3FFFFFF, 'h200000),
                       pick_value('hFFFFFF, 'h400000),
                       pick_value('h3FFFFFF, 'h100000),
                       pick_value('hFFFFFFF, 50000));
      end
      tx_burst = (ph == 4) ? PhaseWords : 0;
      for (i = 0; i < PhaseWords; i++) begin
        // pause mid-phase until every result is back
        if (ph == 3 && i == PhaseWords / 2) drain();
        r = $urandom_range(0, 99);
        if (r < 60) begin
          rr = $urandom_range(0, 9);
          e = 16'($urandom);
          if (rr == 0) e = 16'h8000;
          else if (rr == 1) e = 16'h7FFF;
          else if (rr == 2) e = 16'h0000;
          else if (rr < 6) e = 16'($urandom_range(0, 4095)) - 16'd2048;
          rr = $urandom_range(0, 19);
          b = 16'($urandom);
          if (rr == 0) b = 16'h0000;
          else if (rr == 1) b = 16'hFFFF;
          else if (rr < 14) b = 16'($urandom_range(1, 1024));
          send_update(e, b);
        end else begin
          rr = $urandom_range(0, 19);
          el = 20'($urandom);
          if (rr == 0) el = 20'd0;
          else if (rr == 1) el = 20'hFFFFF;
          else if (rr < 14) el = 20'($urandom_range(1, 5000));
          send_check(el);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d control updates and %0d drift checks over %0d register settings,",
             board.n_updates, board.n_checks, n_settings);
    $display("including timer saturation, zero slew, a lowered limit and a long output stall.");
    if (board.n_errors == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
